>>> rtl/adaptive_range_encoder_defines.svh
// ----------------------------------------------------------------------------
// Adaptive range encoder assertion macros
// Shared concurrent assertion forms, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_RANGE_ENCODER_DEFINES_SVH
`define ADAPTIVE_RANGE_ENCODER_DEFINES_SVH

// same-cycle implication
`define ARE_AST_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define ARE_AST_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> rtl/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg
// Types, codes and constants shared by the adaptive range encoder modules.
// ----------------------------------------------------------------------------
package are_pkg;

	localparam int NUM_SYMBOLS_DEF = 256;
	localparam int FLUSH_BYTES     = 8;
	localparam logic [31:0] RANGE_TOP = 32'h0100_0000;

	localparam logic [7:0]  COUNT_STEP_RST  = 8'd4;
	localparam logic [15:0] TOTAL_LIMIT_RST = 16'd65520;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_STEP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LIMIT = 1'd1;

	typedef struct packed {
		logic       fin;
		logic [7:0] sym;
	} item_t;

	typedef struct packed {
		logic [7:0]  sym;
		logic [15:0] cnt;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_MULC,
		ST_MULF,
		ST_RENORM,
		ST_UPD,
		ST_HALVE,
		ST_SWAP_RD,
		ST_SWAP_CMP,
		ST_SWAP_WR,
		ST_FLUSH
	} core_state_t;

endpackage

>>> rtl/are_front.sv
// ----------------------------------------------------------------------------
// are_front
// Input side: accepts items, tags finish items, two-entry queue to the core.
// ----------------------------------------------------------------------------
module are_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          func,
	input  logic [7:0]    symbol,
	output are_pkg::item_t q_item,
	output logic          q_valid,
	input  logic          q_pop
);

	are_pkg::item_t buf_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       push;
	logic       pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q].fin <= func;
			buf_q[wp_q].sym <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/are_div.sv
// ----------------------------------------------------------------------------
// are_div
// Restoring divider, 32-bit dividend by 17-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module are_div (
	input  logic              clk,
	input  logic              arst_n,
	input  are_pkg::div_req_t req,
	output logic [31:0]       quo,
	output logic              done
);

	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign quo   = quo_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= 17'd1;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= (req.divisor == 17'd0) ? 17'd1 : req.divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? 17'(trial - {1'b0, dvs_q}) : trial[16:0];
			quo_q <= {quo_q[30:0], ge};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/are_core.sv
// ----------------------------------------------------------------------------
// are_core
// Back end: frequency list memory, model update and range coder sequencer.
// ----------------------------------------------------------------------------
module are_core #(
	parameter int NUM_SYMBOLS = are_pkg::NUM_SYMBOLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  are_pkg::item_t q_item,
	input  logic           q_valid,
	output logic           q_pop,
	input  logic [7:0]     count_step,
	input  logic [15:0]    total_limit,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           run_last
);

	localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int IW = $clog2(NUM_SYMBOLS + 1);
	localparam logic [IW-1:0] IDX_END  = IW'(NUM_SYMBOLS);
	localparam logic [AW-1:0] ADDR_TOP = AW'(NUM_SYMBOLS - 1);
	localparam logic [3:0]    N_FLUSH  = 4'(are_pkg::FLUSH_BYTES);

	are_pkg::core_state_t state_q, state_d;

	// list memory, valid bit per entry; an unwritten entry reads as its reset value
	are_pkg::entry_t mem [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] vld_q;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            we;
	logic [AW-1:0]   wr_addr;
	are_pkg::entry_t wr_data;
	logic            clr_all;

	logic            rd_en_s1;
	logic [AW-1:0]   rd_addr_s1;
	are_pkg::entry_t rd_data_s1;
	logic            rd_vld_s1;
	logic [7:0]      ent_sym;
	logic [15:0]     ent_cnt;

	logic [IW-1:0] idx_q;
	logic [AW-1:0] pos_q;
	logic [7:0]    sym_q;
	logic [16:0]   cum_q;
	logic [15:0]   freq_q;
	logic [16:0]   total_q;
	logic [63:0]   low_q;
	logic [31:0]   range_q;
	logic [48:0]   prod_q;
	logic [16:0]   c_q;
	logic [15:0]   ncnt_q;
	logic [16:0]   tsum_q;
	logic [3:0]    n_q;
	logic [7:0]    p1_sym_q;
	logic [15:0]   p1_cnt_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          run_last_q;

	are_pkg::div_req_t div_req;
	logic [31:0]       div_quo;
	logic              div_done;

	logic        found;
	logic        out_free;
	logic        emit;
	logic        emit_last;
	logic        cont;
	logic [63:0] low_sum;
	logic        carry;
	logic [31:0] cut;
	logic [31:0] rng_eff;
	logic [31:0] rng_next;
	logic [17:0] nt;
	logic        need_halve;
	logic [16:0] hv_in;
	logic [16:0] hv;
	logic [16:0] hc;

	are_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign ent_sym = rd_vld_s1 ? rd_data_s1.sym : 8'(rd_addr_s1);
	assign ent_cnt = rd_vld_s1 ? rd_data_s1.cnt : 16'd1;
	assign found   = rd_en_s1 && (ent_sym == sym_q);

	assign out_free = !out_valid_q || !out_stall;

	// renormalization step
	assign cont     = (range_q < are_pkg::RANGE_TOP) && (n_q < N_FLUSH);
	assign low_sum  = low_q + {32'd0, range_q};
	assign carry    = ((low_q[63:56] ^ low_sum[63:56]) != 8'd0);
	assign cut      = (low_q[31:0] | (are_pkg::RANGE_TOP - 32'd1)) - low_q[31:0];
	assign rng_eff  = carry ? ((cut == 32'd0) ? 32'd1 : cut) : range_q;
	assign rng_next = {rng_eff[23:0], 8'd0};

	// model update
	assign nt         = {1'b0, total_q} + 18'(count_step);
	assign need_halve = (nt > 18'(total_limit));
	assign hv_in      = (rd_addr_s1 == pos_q) ? c_q : {1'b0, ent_cnt};
	assign hv         = hv_in - (hv_in >> 1);
	assign hc         = c_q - (c_q >> 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			are_pkg::ST_IDLE: begin
				if (q_valid)
					state_d = q_item.fin ? are_pkg::ST_FLUSH : are_pkg::ST_WALK;
			end
			are_pkg::ST_WALK: begin
				if (found)
					state_d = are_pkg::ST_DIV;
				else if (rd_en_s1 && rd_addr_s1 == ADDR_TOP)
					state_d = are_pkg::ST_IDLE;
			end
			are_pkg::ST_DIV: begin
				if (div_done)
					state_d = are_pkg::ST_MULC;
			end
			are_pkg::ST_MULC:   state_d = are_pkg::ST_MULF;
			are_pkg::ST_MULF:   state_d = are_pkg::ST_RENORM;
			are_pkg::ST_RENORM: begin
				if (!cont)
					state_d = are_pkg::ST_UPD;
			end
			are_pkg::ST_UPD:
				state_d = need_halve ? are_pkg::ST_HALVE : are_pkg::ST_SWAP_RD;
			are_pkg::ST_HALVE: begin
				if (rd_en_s1 && rd_addr_s1 == ADDR_TOP)
					state_d = are_pkg::ST_SWAP_RD;
			end
			are_pkg::ST_SWAP_RD:
				state_d = (pos_q == '0) ? are_pkg::ST_IDLE : are_pkg::ST_SWAP_CMP;
			are_pkg::ST_SWAP_CMP:
				state_d = (ncnt_q > ent_cnt) ? are_pkg::ST_SWAP_WR : are_pkg::ST_IDLE;
			are_pkg::ST_SWAP_WR: state_d = are_pkg::ST_IDLE;
			are_pkg::ST_FLUSH: begin
				if (emit && n_q == N_FLUSH - 4'd1)
					state_d = are_pkg::ST_IDLE;
			end
			default: state_d = are_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q[AW-1:0];
		we        = 1'b0;
		wr_addr   = pos_q;
		wr_data   = '{sym: sym_q, cnt: ncnt_q};
		clr_all   = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		div_req   = '{start: 1'b0, dividend: range_q, divisor: total_q};
		unique case (state_q)
			are_pkg::ST_IDLE: q_pop = q_valid;
			are_pkg::ST_WALK: begin
				rd_en         = (idx_q != IDX_END);
				div_req.start = found;
			end
			are_pkg::ST_RENORM: begin
				emit      = cont && out_free;
				emit_last = !((rng_next < are_pkg::RANGE_TOP) &&
					(n_q + 4'd1 < N_FLUSH));
			end
			are_pkg::ST_UPD: begin
				if (!need_halve) begin
					we      = 1'b1;
					wr_data = '{sym: sym_q, cnt: c_q[15:0]};
				end
			end
			are_pkg::ST_HALVE: begin
				rd_en = (idx_q != IDX_END);
				if (rd_en_s1) begin
					we      = 1'b1;
					wr_addr = rd_addr_s1;
					wr_data = '{sym: ent_sym, cnt: hv[15:0]};
				end
			end
			are_pkg::ST_SWAP_RD: begin
				rd_en   = (pos_q != '0);
				rd_addr = pos_q - AW'(1);
			end
			are_pkg::ST_SWAP_CMP: begin
				if (ncnt_q > ent_cnt) begin
					we      = 1'b1;
					wr_addr = pos_q - AW'(1);
				end
			end
			are_pkg::ST_SWAP_WR: begin
				we      = 1'b1;
				wr_data = '{sym: p1_sym_q, cnt: p1_cnt_q};
			end
			are_pkg::ST_FLUSH: begin
				emit      = out_free;
				emit_last = (n_q == N_FLUSH - 4'd1);
				clr_all   = emit && emit_last;
			end
			default: ;
		endcase
	end

	// list memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
		rd_addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_en_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_en_s1  <= rd_en;
			rd_vld_s1 <= vld_q[rd_addr];
			if (clr_all)
				vld_q <= '0;
			else if (we)
				vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= are_pkg::ST_IDLE;
			idx_q       <= '0;
			pos_q       <= '0;
			sym_q       <= '0;
			cum_q       <= '0;
			freq_q      <= '0;
			total_q     <= 17'(NUM_SYMBOLS);
			low_q       <= '0;
			range_q     <= '1;
			prod_q      <= '0;
			c_q         <= '0;
			ncnt_q      <= '0;
			tsum_q      <= '0;
			n_q         <= '0;
			p1_sym_q    <= '0;
			p1_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			run_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= low_q[63:56];
				run_last_q  <= emit_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				are_pkg::ST_IDLE: begin
					if (q_valid) begin
						sym_q <= q_item.sym;
						idx_q <= '0;
						cum_q <= '0;
						n_q   <= '0;
					end
				end
				are_pkg::ST_WALK: begin
					if (rd_en)
						idx_q <= idx_q + IW'(1);
					if (found) begin
						pos_q  <= rd_addr_s1;
						freq_q <= ent_cnt;
					end else if (rd_en_s1) begin
						cum_q <= cum_q + 17'(ent_cnt);
					end
				end
				are_pkg::ST_MULC: prod_q <= cum_q * div_quo;
				are_pkg::ST_MULF: begin
					low_q   <= low_q + 64'(prod_q);
					range_q <= 32'(div_quo * {16'd0, freq_q});
					c_q     <= 17'(freq_q) + 17'(count_step);
				end
				are_pkg::ST_RENORM: begin
					if (emit) begin
						low_q   <= {low_q[55:0], 8'd0};
						range_q <= rng_next;
						n_q     <= n_q + 4'd1;
					end
				end
				are_pkg::ST_UPD: begin
					if (need_halve) begin
						idx_q  <= '0;
						tsum_q <= '0;
						ncnt_q <= hc[15:0];
					end else begin
						total_q <= nt[16:0];
						ncnt_q  <= c_q[15:0];
					end
				end
				are_pkg::ST_HALVE: begin
					if (rd_en)
						idx_q <= idx_q + IW'(1);
					if (rd_en_s1) begin
						tsum_q <= tsum_q + hv;
						if (rd_addr_s1 == ADDR_TOP)
							total_q <= tsum_q + hv;
					end
				end
				are_pkg::ST_SWAP_CMP: begin
					p1_sym_q <= ent_sym;
					p1_cnt_q <= ent_cnt;
				end
				are_pkg::ST_FLUSH: begin
					if (emit) begin
						n_q <= n_q + 4'd1;
						if (emit_last) begin
							low_q   <= '0;
							range_q <= '1;
							total_q <= 17'(NUM_SYMBOLS);
						end else begin
							low_q <= {low_q[55:0], 8'd0};
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

>>> rtl/adaptive_range_encoder.sv
// ----------------------------------------------------------------------------
// adaptive_range_encoder
// Byte-symbol compressor: adaptive order-0 model with a carry-less range coder.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall, func, symbol): func 0 codes symbol,
//  func 1 ends the block, flushes 8 bytes of low and resets coder and model.
//  Output channel (out_valid/out_stall): one item per compressed byte;
//  run_last marks the last byte caused by an input item. An encode item
//  gives 0 to 4 bytes, a finish item always 8.
//  Config channel (cfg_valid/cfg_ready, always ready): index 0 count_step,
//  index 1 total_limit. Write only while idle.
//  Sequence: an encode item walks the list (one memory read a cycle, up to
//  its position), waits on the serial divider, runs the multiply steps
//  MULC and MULF, renormalizes while emitting output bytes, then runs the
//  update step and a swap (read, compare, write) where one is due. When the
//  total passes total_limit a halving sweep over the list runs before the swap.
//  A finish item only runs the flush.
//  Two input items queue in front of the core, so input is taken while the
//  core works. A stalled output holds the core at its next byte.
//  Reset: list, counts, coder and registers return to defaults at once; the
//  list has a valid bit per entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "adaptive_range_encoder_defines.svh"

module adaptive_range_encoder #(
	parameter int NUM_SYMBOLS = are_pkg::NUM_SYMBOLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [7:0]                    symbol,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          run_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [are_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	// configuration registers
	logic [7:0]  count_step_q;
	logic [15:0] total_limit_q;

	// front to core queue
	are_pkg::item_t q_item;
	logic           q_valid;
	logic           q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_step_q  <= are_pkg::COUNT_STEP_RST;
			total_limit_q <= are_pkg::TOTAL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				are_pkg::CFG_COUNT_STEP:  count_step_q  <= cfg_data[7:0];
				are_pkg::CFG_TOTAL_LIMIT: total_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	are_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.symbol   (symbol),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop)
	);

	are_core #(
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_item      (q_item),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.count_step  (count_step_q),
		.total_limit (total_limit_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last)
	);

	// core pops only an item that is queued
	`ARE_AST_SAME(a_pop_has_item, q_pop, q_valid)
	// an accepted item is queued for the core next cycle
	`ARE_AST_NEXT(a_push_queued, in_valid && !in_stall, q_valid)

endmodule
